[sv/dfpe_pkg.sv]
// shared types and constants of the frame pulse encoder
package dfpe_pkg;

  // field widths
  localparam int unsigned ThrW   = 11;
  localparam int unsigned ScaleW = 4;
  localparam int unsigned TimeW  = 10;
  localparam int unsigned StickW = 8;
  localparam int unsigned FrameW = 16;
  localparam int unsigned CntW   = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // queue between front and back
  localparam int unsigned FifoDepthDef = 2;

  // frame values below this carry the marker bit
  localparam logic [11:0] CmdLimit = 12'd48;

  // register reset values
  localparam logic [ThrW-1:0]   MinThrRst   = 11'd63;
  localparam logic [ThrW-1:0]   MaxThrRst   = 11'd500;
  localparam logic [ScaleW-1:0] ScaleRst    = 4'd3;
  localparam logic [TimeW-1:0]  ZeroHighRst = 10'd60;
  localparam logic [TimeW-1:0]  ZeroLowRst  = 10'd86;
  localparam logic [TimeW-1:0]  OneHighRst  = 10'd119;
  localparam logic [TimeW-1:0]  OneLowRst   = 10'd32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgMinThr   = 3'd0,
    CfgMaxThr   = 3'd1,
    CfgScale    = 3'd2,
    CfgZeroHigh = 3'd3,
    CfgZeroLow  = 3'd4,
    CfgOneHigh  = 3'd5,
    CfgOneLow   = 3'd6
  } cfg_idx_e;

  // one encoded frame waiting in the queue
  typedef struct packed {
    logic [ThrW-1:0]   throttle;
    logic [FrameW-1:0] frame;
  } entry_t;

  // symbol durations handed to the back end
  typedef struct packed {
    logic [TimeW-1:0] zero_high;
    logic [TimeW-1:0] zero_low;
    logic [TimeW-1:0] one_high;
    logic [TimeW-1:0] one_low;
  } timing_t;

endpackage

[sv/dshot_frame_pulse_encoder_unit.sv]
// top level of the frame pulse encoder
//
// Input channel (push / full): one frame request per item, with an
// optional new signed stick byte. The front end updates the held magnitude,
// works out the clamped throttle and the 16-bit frame in the cycle of the
// push, and writes it into a two-entry queue.
// Result channel (empty / pop): sixteen symbol items per request, frame
// MSB first, each with throttle, bit, high and low durations; last_symbol_o
// marks the sixteenth. The first symbol shows once the queue has passed the
// frame on to the back-end shift register. Throughput: one symbol per cycle
// while pop is held and empty is low, set by the back-end serialiser; the
// queue takes further requests while a frame is still going out.
// A stalled receiver holds the current symbol; requests keep being taken
// until the queue is full, then full rises.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready; the user must write
// it only while the block is idle, which the block does not enforce. Reset loads
// the default durations and limits and clears the held magnitude and the queue.
module dshot_frame_pulse_encoder_unit #(
  parameter int unsigned FifoDepth = dfpe_pkg::FifoDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [dfpe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dfpe_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               push,
  output logic                               full,
  input  logic                               sample_valid_i,
  input  logic signed [dfpe_pkg::StickW-1:0] stick_value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic [dfpe_pkg::ThrW-1:0]          throttle_value_o,
  output logic                               symbol_bit_o,
  output logic [dfpe_pkg::TimeW-1:0]         high_time_o,
  output logic [dfpe_pkg::TimeW-1:0]         low_time_o,
  output logic                               last_symbol_o
);

  dfpe_pkg::entry_t  enc_entry, q_entry;
  dfpe_pkg::timing_t timing;
  logic              accept, q_valid, q_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // front end
  dfpe_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .sample_valid_i (sample_valid_i),
    .stick_value_i  (stick_value_i),
    .entry_o        (enc_entry),
    .timing_o       (timing)
  );

  // frame queue
  dfpe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept),
    .wr_data_i  (enc_entry),
    .full_o     (full),
    .rd_valid_o (q_valid),
    .rd_en_i    (q_pop),
    .rd_data_o  (q_entry)
  );

  // back end
  dfpe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_data_i         (q_entry),
    .q_pop_o          (q_pop),
    .timing_i         (timing),
    .pop_i            (pop),
    .empty_o          (empty),
    .throttle_value_o (throttle_value_o),
    .symbol_bit_o     (symbol_bit_o),
    .high_time_o      (high_time_o),
    .low_time_o       (low_time_o),
    .last_symbol_o    (last_symbol_o)
  );

endmodule

[sv/dfpe_front.sv]
// front end: configuration registers, stick magnitude store and frame encoding
module dfpe_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [dfpe_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [dfpe_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               accept_i,
  input  logic                               sample_valid_i,
  input  logic signed [dfpe_pkg::StickW-1:0] stick_value_i,
  output dfpe_pkg::entry_t                   entry_o,
  output dfpe_pkg::timing_t                  timing_o
);

  logic [dfpe_pkg::ThrW-1:0]   min_thr_q, max_thr_q;
  logic [dfpe_pkg::ScaleW-1:0] scale_q;
  dfpe_pkg::timing_t           timing_q;
  logic [dfpe_pkg::StickW-1:0] mag_q, mag_d, new_mag;
  logic signed [8:0]           mag_s;
  logic signed [13:0]          prod, sum;
  logic [12:0]                 t_lo;
  logic [dfpe_pkg::ThrW-1:0]   thr;
  logic [11:0]                 v;
  logic [3:0]                  cs;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_thr_q          <= dfpe_pkg::MinThrRst;
      max_thr_q          <= dfpe_pkg::MaxThrRst;
      scale_q            <= dfpe_pkg::ScaleRst;
      timing_q.zero_high <= dfpe_pkg::ZeroHighRst;
      timing_q.zero_low  <= dfpe_pkg::ZeroLowRst;
      timing_q.one_high  <= dfpe_pkg::OneHighRst;
      timing_q.one_low   <= dfpe_pkg::OneLowRst;
    end else if (cfg_valid_i) begin
      case (dfpe_pkg::cfg_idx_e'(cfg_index_i))
        dfpe_pkg::CfgMinThr:   min_thr_q          <= cfg_data_i;
        dfpe_pkg::CfgMaxThr:   max_thr_q          <= cfg_data_i;
        dfpe_pkg::CfgScale:    scale_q            <= cfg_data_i[dfpe_pkg::ScaleW-1:0];
        dfpe_pkg::CfgZeroHigh: timing_q.zero_high <= cfg_data_i[dfpe_pkg::TimeW-1:0];
        dfpe_pkg::CfgZeroLow:  timing_q.zero_low  <= cfg_data_i[dfpe_pkg::TimeW-1:0];
        dfpe_pkg::CfgOneHigh:  timing_q.one_high  <= cfg_data_i[dfpe_pkg::TimeW-1:0];
        dfpe_pkg::CfgOneLow:   timing_q.one_low   <= cfg_data_i[dfpe_pkg::TimeW-1:0];
        default: ;
      endcase
    end
  end

  assign timing_o = timing_q;

  // magnitude of the stick byte, 128 wraps to -128 in the store
  assign new_mag = stick_value_i[dfpe_pkg::StickW-1] ? 8'(-stick_value_i)
                                                     : 8'(stick_value_i);
  assign mag_d   = sample_valid_i ? new_mag : mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= '0;
    end else if (accept_i) begin
      mag_q <= mag_d;
    end
  end

  // throttle: signed magnitude times scale plus minimum, then clamps
  always_comb begin
    mag_s = $signed({mag_d[7], mag_d});
    prod  = $signed({{5{mag_s[8]}}, mag_s}) * $signed({10'b0, scale_q});
    sum   = prod + $signed({3'b0, min_thr_q});
    t_lo  = (sum[12:0] < {2'b0, min_thr_q}) ? {2'b0, min_thr_q} : sum[12:0];
    if (sum[13]) begin
      // negative sum wraps above every maximum
      thr = max_thr_q;
    end else if (t_lo > {2'b0, max_thr_q}) begin
      thr = max_thr_q;
    end else begin
      thr = t_lo[dfpe_pkg::ThrW-1:0];
    end
  end

  // frame word with marker bit and nibble checksum
  always_comb begin
    v = {thr, 1'b0};
    if (v < dfpe_pkg::CmdLimit) begin
      v[0] = 1'b1;
    end
    cs = v[3:0] ^ v[7:4] ^ v[11:8];
    entry_o.throttle = thr;
    entry_o.frame    = {v, cs};
  end

endmodule

[sv/dfpe_fifo.sv]
// short queue of encoded frames between front and back
module dfpe_fifo #(
  parameter int unsigned Depth = dfpe_pkg::FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  dfpe_pkg::entry_t wr_data_i,
  output logic             full_o,
  output logic             rd_valid_o,
  input  logic             rd_en_i,
  output dfpe_pkg::entry_t rd_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dfpe_pkg::entry_t  mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign rd_valid_o = (cnt_q != '0);
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[sv/dfpe_back.sv]
// back end: serialises one frame into sixteen symbol items
module dfpe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  dfpe_pkg::entry_t              q_data_i,
  output logic                          q_pop_o,
  input  dfpe_pkg::timing_t             timing_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic [dfpe_pkg::ThrW-1:0]     throttle_value_o,
  output logic                          symbol_bit_o,
  output logic [dfpe_pkg::TimeW-1:0]    high_time_o,
  output logic [dfpe_pkg::TimeW-1:0]    low_time_o,
  output logic                          last_symbol_o
);

  logic                          busy_q;
  logic [dfpe_pkg::CntW-1:0]     cnt_q;
  logic [dfpe_pkg::FrameW-1:0]   frame_q;
  logic [dfpe_pkg::ThrW-1:0]     thr_q;
  logic                          taken, last, load;

  assign taken = pop_i && busy_q;
  assign last  = (cnt_q == {dfpe_pkg::CntW{1'b1}});
  assign load  = q_valid_i && (!busy_q || (taken && last));
  assign q_pop_o = load;

  // symbol counter and frame shifter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (taken) begin
      cnt_q <= cnt_q + 1'b1;
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= q_data_i.frame;
      thr_q   <= q_data_i.throttle;
    end else if (taken) begin
      frame_q <= {frame_q[dfpe_pkg::FrameW-2:0], 1'b0};
    end
  end

  // result fields of the current symbol
  assign empty_o          = !busy_q;
  assign throttle_value_o = thr_q;
  assign symbol_bit_o     = frame_q[dfpe_pkg::FrameW-1];
  assign high_time_o      = symbol_bit_o ? timing_i.one_high : timing_i.zero_high;
  assign low_time_o       = symbol_bit_o ? timing_i.one_low : timing_i.zero_low;
  assign last_symbol_o    = last;

endmodule

[sim/tb_dshot_frame_pulse_encoder_unit.sv]
// self-checking testbench of the frame pulse encoder, checked symbol by symbol
`timescale 1ns / 1ps

module tb_dshot_frame_pulse_encoder_unit;

  // index past the last register, writes to it must be ignored
  localparam logic [dfpe_pkg::CfgIdxW-1:0] CfgSpareIdx = 3'd7;
  localparam int HoldOffCycles = 400;
  localparam int SettleCycles  = 8;
  localparam int RandomPhases  = 4;
  localparam int PhaseItems    = 40;
  localparam int ReportLimit   = 10;

  // one symbol item as seen on the result ports
  typedef struct packed {
    logic [dfpe_pkg::ThrW-1:0]  throttle;
    logic                       sym_bit;
    logic [dfpe_pkg::TimeW-1:0] high_t;
    logic [dfpe_pkg::TimeW-1:0] low_t;
    logic                       last;
  } symbol_t;

  // register copy, held magnitude and the symbols still to come
  class frame_symbol_tracker;
    logic [dfpe_pkg::ThrW-1:0]   min_thr;
    logic [dfpe_pkg::ThrW-1:0]   max_thr;
    logic [dfpe_pkg::ScaleW-1:0] scale;
    logic [dfpe_pkg::TimeW-1:0]  zero_hi;
    logic [dfpe_pkg::TimeW-1:0]  zero_lo;
    logic [dfpe_pkg::TimeW-1:0]  one_hi;
    logic [dfpe_pkg::TimeW-1:0]  one_lo;
    logic [dfpe_pkg::StickW-1:0] held_mag;
    symbol_t                     expected_symbols[$];
    int                          n_errors;
    int                          n_checked;
    int                          n_requests;

    function new();
      min_thr    = dfpe_pkg::MinThrRst;
      max_thr    = dfpe_pkg::MaxThrRst;
      scale      = dfpe_pkg::ScaleRst;
      zero_hi    = dfpe_pkg::ZeroHighRst;
      zero_lo    = dfpe_pkg::ZeroLowRst;
      one_hi     = dfpe_pkg::OneHighRst;
      one_lo     = dfpe_pkg::OneLowRst;
      held_mag   = '0;
      n_errors   = 0;
      n_checked  = 0;
      n_requests = 0;
    endfunction

    function void set_register(logic [dfpe_pkg::CfgIdxW-1:0] idx,
                               logic [dfpe_pkg::CfgDataW-1:0] data);
      case (idx)
        dfpe_pkg::CfgMinThr:   min_thr = data[dfpe_pkg::ThrW-1:0];
        dfpe_pkg::CfgMaxThr:   max_thr = data[dfpe_pkg::ThrW-1:0];
        dfpe_pkg::CfgScale:    scale   = data[dfpe_pkg::ScaleW-1:0];
        dfpe_pkg::CfgZeroHigh: zero_hi = data[dfpe_pkg::TimeW-1:0];
        dfpe_pkg::CfgZeroLow:  zero_lo = data[dfpe_pkg::TimeW-1:0];
        dfpe_pkg::CfgOneHigh:  one_hi  = data[dfpe_pkg::TimeW-1:0];
        dfpe_pkg::CfgOneLow:   one_lo  = data[dfpe_pkg::TimeW-1:0];
        default: ;
      endcase
    endfunction

    // magnitude times scale plus offset, then clamp up to min and down to max
    function logic [dfpe_pkg::ThrW-1:0] clamped_throttle();
      int          mag;
      int          sc;
      int          offs;
      int          sum;
      int unsigned t;
      mag  = $signed(held_mag);
      sc   = scale;
      offs = min_thr;
      sum  = mag * sc + offs;
      // a negative sum wraps far above any 11-bit maximum
      if (sum < 0) t = 32'hFFFF;
      else t = sum;
      if (t < min_thr) t = min_thr;
      if (t > max_thr) t = max_thr;
      return t[dfpe_pkg::ThrW-1:0];
    endfunction

    function void note_request(logic valid, logic [dfpe_pkg::StickW-1:0] stick);
      logic [dfpe_pkg::ThrW-1:0]   thr;
      logic [dfpe_pkg::ThrW:0]     v;
      logic [dfpe_pkg::FrameW-1:0] frame;
      symbol_t                     s;
      int                          k;
      // magnitude of -128 wraps back to 8'h80 in the store
      if (valid) held_mag = stick[dfpe_pkg::StickW-1] ? 8'd0 - stick : stick;
      thr = clamped_throttle();
      v = {thr, 1'b0};
      if (v < dfpe_pkg::CmdLimit) v[0] = 1'b1;
      frame = {v, v[3:0] ^ v[7:4] ^ v[11:8]};
      for (k = 0; k < dfpe_pkg::FrameW; k++) begin
        s.throttle = thr;
        s.sym_bit  = frame[dfpe_pkg::FrameW-1-k];
        s.high_t   = s.sym_bit ? one_hi : zero_hi;
        s.low_t    = s.sym_bit ? one_lo : zero_lo;
        s.last     = (k == dfpe_pkg::FrameW - 1);
        expected_symbols.push_back(s);
      end
      n_requests++;
    endfunction

    function void check_symbol(symbol_t got);
      symbol_t want;
      n_checked++;
      if (expected_symbols.size() == 0) begin
        n_errors++;
        if (n_errors <= ReportLimit)
          $display("symbol %0d: unexpected item, thr %0d bit %0b hi %0d lo %0d last %0b",
                   n_checked, got.throttle, got.sym_bit, got.high_t, got.low_t, got.last);
        return;
      end
      want = expected_symbols.pop_front();
      if (got.throttle !== want.throttle || got.sym_bit !== want.sym_bit ||
          got.high_t !== want.high_t || got.low_t !== want.low_t ||
          got.last !== want.last) begin
        n_errors++;
        if (n_errors <= ReportLimit) begin
          $display("symbol %0d: expected thr %0d bit %0b hi %0d lo %0d last %0b", n_checked,
                   want.throttle, want.sym_bit, want.high_t, want.low_t, want.last);
          $display("symbol %0d:      got thr %0d bit %0b hi %0d lo %0d last %0b", n_checked,
                   got.throttle, got.sym_bit, got.high_t, got.low_t, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction
  endclass

  logic                               clk_i          = 1'b0;
  logic                               rst_ni         = 1'b0;
  logic                               cfg_valid_i    = 1'b0;
  logic                               cfg_ready_o;
  logic [dfpe_pkg::CfgIdxW-1:0]       cfg_index_i    = '0;
  logic [dfpe_pkg::CfgDataW-1:0]      cfg_data_i     = '0;
  logic                               push           = 1'b0;
  logic                               full;
  logic                               sample_valid_i = 1'b0;
  logic signed [dfpe_pkg::StickW-1:0] stick_value_i  = '0;
  logic                               empty;
  logic                               pop            = 1'b0;
  logic [dfpe_pkg::ThrW-1:0]          throttle_value_o;
  logic                               symbol_bit_o;
  logic [dfpe_pkg::TimeW-1:0]         high_time_o;
  logic [dfpe_pkg::TimeW-1:0]         low_time_o;
  logic                               last_symbol_o;

  frame_symbol_tracker tracker = new();
  bit hold_req       = 1'b0;
  int n_holds        = 0;
  int n_full_stalls  = 0;
  int n_settings     = 0;
  int burst_left     = 0;

  dshot_frame_pulse_encoder_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .push             (push),
    .full             (full),
    .sample_valid_i   (sample_valid_i),
    .stick_value_i    (stick_value_i),
    .empty            (empty),
    .pop              (pop),
    .throttle_value_o (throttle_value_o),
    .symbol_bit_o     (symbol_bit_o),
    .high_time_o      (high_time_o),
    .low_time_o       (low_time_o),
    .last_symbol_o    (last_symbol_o)
  );

  // clock
  always #2 clk_i = ~clk_i;

  // watchdog
  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // observe handshakes on all three channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) tracker.set_register(cfg_index_i, cfg_data_i);
      if (push && !full) tracker.note_request(sample_valid_i, stick_value_i);
      if (push && full) n_full_stalls++;
      if (pop && !empty)
        tracker.check_symbol(symbol_t'{throttle_value_o, symbol_bit_o, high_time_o,
                                       low_time_o, last_symbol_o});
    end
  end

  // receiver: runs of its own stall patterns, plus one long hold-off on request
  initial begin
    int         mode;
    int         len;
    int         stall_len;
    int         i;
    logic [7:0] pat;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_req = 1'b0;
        n_holds++;
      end else begin
        mode      = $urandom_range(0, 3);
        len       = $urandom_range(8, 48);
        stall_len = $urandom_range(1, 12);
        pat       = 8'($urandom_range(1, 255));
        for (i = 0; i < len; i++) begin
          case (mode)
            0: pop <= 1'b1;
            1: pop <= pat[i % 8];
            2: pop <= 1'($urandom_range(0, 1));
            default: pop <= (i % (stall_len + 4)) >= stall_len;
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // offer one request and hold it until taken
  task automatic send_item(input logic valid, input logic [dfpe_pkg::StickW-1:0] stick);
    push           <= 1'b1;
    sample_valid_i <= valid;
    stick_value_i  <= stick;
    do @(posedge clk_i); while (full);
  endtask

  // sender bursts with random gaps, noise on the data lines while idle
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        push           <= 1'b0;
        sample_valid_i <= 1'($urandom_range(0, 1));
        stick_value_i  <= 8'($urandom_range(0, 255));
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_paced(input logic valid, input logic [dfpe_pkg::StickW-1:0] stick);
    send_item(valid, stick);
    pace_sender();
  endtask

  // stop offering and wait until every symbol has come out
  task automatic drain();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dfpe_pkg::CfgIdxW-1:0] idx,
                           input logic [dfpe_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(input logic [dfpe_pkg::CfgDataW-1:0] min_v,
                                input logic [dfpe_pkg::CfgDataW-1:0] max_v,
                                input logic [dfpe_pkg::CfgDataW-1:0] scale_v,
                                input logic [dfpe_pkg::CfgDataW-1:0] zh,
                                input logic [dfpe_pkg::CfgDataW-1:0] zl,
                                input logic [dfpe_pkg::CfgDataW-1:0] oh,
                                input logic [dfpe_pkg::CfgDataW-1:0] ol);
    write_reg(dfpe_pkg::CfgMinThr, min_v);
    write_reg(dfpe_pkg::CfgMaxThr, max_v);
    write_reg(dfpe_pkg::CfgScale, scale_v);
    write_reg(dfpe_pkg::CfgZeroHigh, zh);
    write_reg(dfpe_pkg::CfgZeroLow, zl);
    write_reg(dfpe_pkg::CfgOneHigh, oh);
    write_reg(dfpe_pkg::CfgOneLow, ol);
    write_reg(CfgSpareIdx, 11'($urandom_range(0, 2047)));
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  // main sequence
  initial begin
    int ph;
    int n;
    logic [dfpe_pkg::StickW-1:0] stick;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: zero, full positive, most negative, held sample, minus one and minus 127
    send_paced(1'b1, 8'h00);
    send_paced(1'b1, 8'h7f);
    send_paced(1'b1, 8'h80);
    send_paced(1'b0, 8'h05);
    send_paced(1'b1, 8'hff);
    send_paced(1'b1, 8'h81);
    send_paced(1'b0, 8'h80);

    // widest range, steepest scale: marker bit on low throttle, wrapped magnitude
    drain();
    apply_settings(11'd0, 11'd2047, 11'd15, 11'd0, 11'd1023, 11'd1023, 11'd0);
    send_paced(1'b1, 8'h00);
    send_paced(1'b1, 8'h01);
    send_paced(1'b1, 8'h7f);
    send_paced(1'b1, 8'h80);
    send_paced(1'b1, 8'hfe);

    // zero scale: wrapped magnitude gives the minimum
    drain();
    apply_settings(11'd0, 11'd2047, 11'd0, 11'd1023, 11'd0, 11'd0, 11'd1023);
    send_paced(1'b1, 8'h80);
    send_paced(1'b1, 8'h7f);

    // minimum above maximum: the maximum wins
    drain();
    apply_settings(11'd2047, 11'd0, 11'd15, 11'd512, 11'd511, 11'd1, 11'd1022);
    send_paced(1'b1, 8'h64);
    send_paced(1'b1, 8'h80);

    // top of the range on both limits
    drain();
    apply_settings(11'd2047, 11'd2047, 11'd1, 11'd341, 11'd682, 11'd1023, 11'd1023);
    send_paced(1'b1, 8'h7f);
    send_paced(1'b0, 8'h00);

    // random settings and requests, one phase with a long receiver hold-off
    for (ph = 0; ph < RandomPhases; ph++) begin
      drain();
      apply_settings(
        11'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 31) : $urandom_range(0, 2047)),
        11'(($urandom_range(0, 1) == 1) ? 2047 : $urandom_range(0, 2047)),
        11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
        11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
        11'($urandom_range(0, 2047)));
      if (ph == 1) hold_req = 1'b1;
      for (n = 0; n < PhaseItems; n++) begin
        case ($urandom_range(0, 9))
          0: stick = 8'h80;
          1: stick = 8'h7f;
          2: stick = 8'h00;
          default: stick = 8'($urandom_range(0, 255));
        endcase
        send_paced($urandom_range(0, 3) != 0, stick);
      end
    end

    drain();
    repeat (32) @(posedge clk_i);
    $display("covered %0d requests under %0d register settings, %0d symbols checked",
             tracker.n_requests, n_settings + 1, tracker.n_checked);
    $display("input held off by full on %0d cycles, %0d long receiver hold-off(s)",
             n_full_stalls, n_holds);
    if (tracker.n_errors == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d symbols outstanding", tracker.n_errors, tracker.pending());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[sim.f]
sv/dfpe_pkg.sv
sv/dfpe_front.sv
sv/dfpe_fifo.sv
sv/dfpe_back.sv
sv/dshot_frame_pulse_encoder_unit.sv
sim/tb_dshot_frame_pulse_encoder_unit.sv
